// ----- hw/rtl/csrgb_pkg.sv -----
// Shared types and constants of the CSR graph builder.
`default_nettype none
package csrgb_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;
	localparam int PART_SPAN = 8;
	localparam int ADJ_DEPTH = MAX_EDGES + MAX_NODES;

	localparam int ID_W   = 11;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int EDGE_W = $clog2(MAX_EDGES);
	localparam int ADJ_W  = $clog2(ADJ_DEPTH);
	localparam int IDX_W  = 13;
	localparam int VAL_W  = 13;
	localparam int NP_W   = 10;
	localparam int PNUM_W = 12;

	localparam logic [VAL_W-1:0] MAX_EDGES_C = VAL_W'(MAX_EDGES);
	localparam logic [ID_W-1:0]  MAX_NODES_C = ID_W'(MAX_NODES);

	localparam logic [2:0] FUNC_ADD      = 3'd0;
	localparam logic [2:0] FUNC_BUILD    = 3'd1;
	localparam logic [2:0] FUNC_RD_START = 3'd2;
	localparam logic [2:0] FUNC_RD_WORD  = 3'd3;
	localparam logic [2:0] FUNC_RD_PART  = 3'd4;
	localparam logic [2:0] FUNC_RD_DEG   = 3'd5;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ERR     = 2'd1;
	localparam logic [1:0] STAT_UNBUILT = 2'd2;

	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_ONE_BASED  = 1'b1;

	typedef enum logic [2:0] {
		OP_ADD, OP_BUILD, OP_RD_START, OP_RD_WORD, OP_RD_PART, OP_RD_DEG, OP_BAD
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              bad;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] nodes;
		logic            one_based;
		logic            nodes_wr;
	} cfg_t;

	typedef enum logic [3:0] {
		BS_CLEAR, BS_IDLE, BS_READ, BS_DONE, BS_B1_RD, BS_B1_WR, BS_B1_PT,
		BS_B2_RD, BS_B2_SRC, BS_B2_WR, BS_BDONE
	} bstate_t;

endpackage
`default_nettype wire

// ----- hw/rtl/csrgb_front.sv -----
// Front stage: accepts items, maps node ids and classifies the command.
`default_nettype none
module csrgb_front import csrgb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        func,
	input  wire logic [ID_W-1:0]   source_node,
	input  wire logic [ID_W-1:0]   dest_node,
	input  wire logic [IDX_W-1:0]  index,
	input  wire cfg_t              cfg,
	input  wire logic              hold,
	input  wire logic              q_full,
	output logic                   q_push,
	output cmd_t                   q_cmd
);

	logic            v_s1;
	cmd_t            cmd_s1;
	cmd_t            cmd_c;
	logic [ID_W-1:0] src_m, dst_m;
	logic            src_ok, dst_ok, idx_ok, accept;

	assign q_push   = v_s1 && !q_full;
	assign in_stall = hold || (v_s1 && q_full);
	assign accept   = in_valid && !in_stall;
	assign q_cmd    = cmd_s1;

	always_comb begin
		src_m  = cfg.one_based ? source_node - ID_W'(1) : source_node;
		dst_m  = cfg.one_based ? dest_node - ID_W'(1) : dest_node;
		src_ok = !(cfg.one_based && source_node == '0) && (src_m < cfg.nodes);
		dst_ok = !(cfg.one_based && dest_node == '0) && (dst_m < cfg.nodes);
		idx_ok = index < IDX_W'(cfg.nodes);
		cmd_c.src = src_m[NODE_W-1:0];
		cmd_c.dst = dst_m[NODE_W-1:0];
		cmd_c.idx = index;
		cmd_c.bad = 1'b0;
		unique case (func)
			FUNC_ADD: begin
				cmd_c.op  = OP_ADD;
				cmd_c.bad = !(src_ok && dst_ok);
			end
			FUNC_BUILD:    cmd_c.op = OP_BUILD;
			FUNC_RD_START: begin
				cmd_c.op  = OP_RD_START;
				cmd_c.bad = !idx_ok;
			end
			FUNC_RD_WORD:  cmd_c.op = OP_RD_WORD;
			FUNC_RD_PART:  cmd_c.op = OP_RD_PART;
			FUNC_RD_DEG: begin
				cmd_c.op  = OP_RD_DEG;
				cmd_c.bad = !idx_ok;
			end
			default:       cmd_c.op = OP_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/csrgb_queue.sv -----
// Two-entry command queue between the front and back stages.
`default_nettype none
module csrgb_queue import csrgb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t       slots_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign empty = count_q == 2'd0;
	assign full  = count_q == 2'd2;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/csrgb_back.sv -----
// Back stage: edge and degree stores, build sequencer and result register.
`default_nettype none
module csrgb_back import csrgb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             q_empty,
	input  wire cmd_t             q_head,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic [VAL_W-1:0]      value_a,
	output logic [VAL_W-1:0]      value_b
);

	logic [VAL_W-1:0]  od_mem [MAX_NODES];
	logic [VAL_W-1:0]  id_mem [MAX_NODES];
	logic [NODE_W-1:0] es_mem [MAX_EDGES];
	logic [NODE_W-1:0] ed_mem [MAX_EDGES];
	logic [VAL_W-1:0]  ns_mem [MAX_NODES];
	logic [VAL_W-1:0]  fc_mem [MAX_NODES];
	logic [VAL_W-1:0]  adj_mem [ADJ_DEPTH];
	logic [NODE_W-1:0] pn_mem [MAX_EDGES];
	logic [PNUM_W-1:0] pp_mem [MAX_EDGES];

	bstate_t           state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [ID_W-1:0]   i_q, i_d, clr_q, clr_d, zeros_q, zeros_d;
	logic [VAL_W-1:0]  pos_q, pos_d, parts_q, parts_d, e_q, e_d;
	logic [VAL_W-1:0]  stored_q, stored_d, ptotal_q, ptotal_d, adjlen_q, adjlen_d;
	logic [NP_W-1:0]   np_q, np_d, p_q, p_d;
	logic              built_q, built_d;
	logic              out_valid_q, out_valid_d;
	logic [1:0]        status_q, status_d;
	logic [VAL_W-1:0]  va_q, va_d, vb_q, vb_d;

	logic              od_we, id_we, es_we, ns_we, fc_we, adj_we, pt_we;
	logic [NODE_W-1:0] od_wa, id_wa, ns_wa, fc_wa, od_ra, id_ra, ns_ra;
	logic [VAL_W-1:0]  od_wd, id_wd, ns_wd, fc_wd, adj_wd;
	logic [EDGE_W-1:0] es_wa, pt_wa;
	logic [ADJ_W-1:0]  adj_wa;
	logic [PNUM_W-1:0] pp_wd;
	logic [VAL_W-1:0]  od_rd, id_rd, ns_rd, fc_rd, adj_rd;
	logic [NODE_W-1:0] es_rd, ed_rd, pn_rd;
	logic [PNUM_W-1:0] pp_rd;
	logic              out_free, finish, add_ok;
	logic [VAL_W:0]    np_sum;

	assign out_free  = !out_valid_q || !out_stall;
	assign clearing  = state_q == BS_CLEAR;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_a   = va_q;
	assign value_b   = vb_q;

	assign od_ra  = (cmd_q.op == OP_BUILD) ? i_q[NODE_W-1:0] :
		(cmd_q.op == OP_RD_DEG) ? cmd_q.idx[NODE_W-1:0] : cmd_q.src;
	assign id_ra  = (cmd_q.op == OP_RD_DEG) ? cmd_q.idx[NODE_W-1:0] : cmd_q.dst;
	assign ns_ra  = (cmd_q.op == OP_BUILD) ? es_rd : cmd_q.idx[NODE_W-1:0];
	assign add_ok = !cmd_q.bad && (stored_q != MAX_EDGES_C);
	assign np_sum = (VAL_W+1)'(od_rd) + (VAL_W+1)'(PART_SPAN - 1);

	always_comb begin
		state_d = state_q;  cmd_d = cmd_q;  i_d = i_q;  clr_d = clr_q;
		zeros_d = zeros_q;  pos_d = pos_q;  parts_d = parts_q;  e_d = e_q;
		stored_d = stored_q;  ptotal_d = ptotal_q;  adjlen_d = adjlen_q;
		np_d = np_q;  p_d = p_q;  built_d = built_q;
		status_d = status_q;  va_d = va_q;  vb_d = vb_q;
		out_valid_d = out_valid_q && out_stall;
		q_pop = 1'b0;  finish = 1'b0;
		od_we = 1'b0;  id_we = 1'b0;  es_we = 1'b0;  ns_we = 1'b0;
		fc_we = 1'b0;  adj_we = 1'b0;  pt_we = 1'b0;
		od_wa = cmd_q.src;  od_wd = od_rd + VAL_W'(1);
		id_wa = cmd_q.dst;  id_wd = id_rd + VAL_W'(1);
		es_wa = stored_q[EDGE_W-1:0];
		ns_wa = i_q[NODE_W-1:0];  ns_wd = pos_q;
		fc_wa = i_q[NODE_W-1:0];  fc_wd = '0;
		adj_wa = pos_q[ADJ_W-1:0];  adj_wd = od_rd;
		pt_wa = parts_q[EDGE_W-1:0];  pp_wd = PNUM_W'(p_q);

		if (cfg.nodes_wr) begin
			built_d = 1'b0;
		end

		unique case (state_q)
			BS_CLEAR: begin
				od_we = 1'b1;  id_we = 1'b1;
				od_wa = clr_q[NODE_W-1:0];  id_wa = clr_q[NODE_W-1:0];
				od_wd = '0;  id_wd = '0;
				clr_d = clr_q + ID_W'(1);
				if (clr_q == MAX_NODES_C - ID_W'(1)) begin
					state_d = BS_IDLE;
				end
			end
			BS_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;  cmd_d = q_head;  state_d = BS_READ;
				end
			end
			BS_READ: begin
				if (cmd_q.op == OP_BUILD) begin
					i_d = '0;  pos_d = '0;  zeros_d = '0;  parts_d = '0;
					state_d = BS_B1_RD;
				end else begin
					state_d = BS_DONE;
				end
			end
			BS_DONE: begin
				if (out_free) begin
					finish = 1'b1;  va_d = '0;  vb_d = '0;  status_d = STAT_OK;
					unique case (cmd_q.op)
						OP_ADD: begin
							status_d = add_ok ? STAT_OK : STAT_ERR;
							va_d = stored_q + VAL_W'(add_ok);
							if (add_ok) begin
								od_we = 1'b1;  id_we = 1'b1;  es_we = 1'b1;
								stored_d = stored_q + VAL_W'(1);
								built_d = 1'b0;
							end
						end
						OP_RD_START: begin
							if (!built_q)        status_d = STAT_UNBUILT;
							else if (cmd_q.bad)  status_d = STAT_ERR;
							else                 va_d = ns_rd;
						end
						OP_RD_WORD: begin
							if (!built_q)                     status_d = STAT_UNBUILT;
							else if (cmd_q.idx >= adjlen_q)   status_d = STAT_ERR;
							else                              va_d = adj_rd;
						end
						OP_RD_PART: begin
							if (!built_q) begin
								status_d = STAT_UNBUILT;
							end else if (cmd_q.idx >= ptotal_q) begin
								status_d = STAT_ERR;
							end else begin
								va_d = VAL_W'(pn_rd);
								vb_d = VAL_W'(pp_rd);
							end
						end
						OP_RD_DEG: begin
							if (cmd_q.bad) begin
								status_d = STAT_ERR;
							end else begin
								va_d = od_rd;
								vb_d = id_rd;
							end
						end
						default: status_d = STAT_ERR;
					endcase
				end
			end
			BS_B1_RD: begin
				if (i_q >= cfg.nodes) begin
					e_d = '0;  state_d = BS_B2_RD;
				end else begin
					state_d = BS_B1_WR;
				end
			end
			BS_B1_WR: begin
				ns_we = 1'b1;  adj_we = 1'b1;  fc_we = 1'b1;
				zeros_d = zeros_q + ID_W'(od_rd == '0);
				pos_d = pos_q + od_rd + VAL_W'(1);
				np_d = NP_W'(np_sum / PART_SPAN);
				p_d = '0;
				state_d = BS_B1_PT;
			end
			BS_B1_PT: begin
				if (p_q < np_q && parts_q < MAX_EDGES_C) begin
					pt_we = 1'b1;
					parts_d = parts_q + VAL_W'(1);
					p_d = p_q + NP_W'(1);
				end else begin
					i_d = i_q + ID_W'(1);
					state_d = BS_B1_RD;
				end
			end
			BS_B2_RD: begin
				state_d = (e_q >= stored_q) ? BS_BDONE : BS_B2_SRC;
			end
			BS_B2_SRC: begin
				if (ID_W'(es_rd) >= cfg.nodes) begin
					e_d = e_q + VAL_W'(1);  state_d = BS_B2_RD;
				end else begin
					state_d = BS_B2_WR;
				end
			end
			BS_B2_WR: begin
				adj_we = 1'b1;  fc_we = 1'b1;
				adj_wa = ADJ_W'(ns_rd + fc_rd + VAL_W'(1));
				adj_wd = VAL_W'(ed_rd);
				fc_wa = es_rd;
				fc_wd = fc_rd + VAL_W'(1);
				e_d = e_q + VAL_W'(1);
				state_d = BS_B2_RD;
			end
			BS_BDONE: begin
				if (out_free) begin
					finish = 1'b1;
					status_d = STAT_OK;
					va_d = parts_q;
					vb_d = VAL_W'(zeros_q);
					built_d = 1'b1;
					ptotal_d = parts_q;
					adjlen_d = pos_q;
				end
			end
			default: state_d = BS_IDLE;
		endcase

		if (finish) begin
			out_valid_d = 1'b1;
			if (!q_empty) begin
				q_pop = 1'b1;  cmd_d = q_head;  state_d = BS_READ;
			end else begin
				state_d = BS_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;  clr_q <= '0;  stored_q <= '0;  ptotal_q <= '0;
			adjlen_q <= '0;  built_q <= 1'b0;  out_valid_q <= 1'b0;
			i_q <= '0;  zeros_q <= '0;  pos_q <= '0;  parts_q <= '0;  e_q <= '0;
			np_q <= '0;  p_q <= '0;
		end else begin
			state_q <= state_d;  clr_q <= clr_d;  stored_q <= stored_d;
			ptotal_q <= ptotal_d;  adjlen_q <= adjlen_d;  built_q <= built_d;
			out_valid_q <= out_valid_d;
			i_q <= i_d;  zeros_q <= zeros_d;  pos_q <= pos_d;  parts_q <= parts_d;
			e_q <= e_d;  np_q <= np_d;  p_q <= p_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;  status_q <= status_d;  va_q <= va_d;  vb_q <= vb_d;
	end

	always_ff @(posedge clk) begin
		if (od_we) od_mem[od_wa] <= od_wd;
		od_rd <= od_mem[od_ra];
	end

	always_ff @(posedge clk) begin
		if (id_we) id_mem[id_wa] <= id_wd;
		id_rd <= id_mem[id_ra];
	end

	always_ff @(posedge clk) begin
		if (es_we) begin
			es_mem[es_wa] <= cmd_q.src;
			ed_mem[es_wa] <= cmd_q.dst;
		end
		es_rd <= es_mem[e_q[EDGE_W-1:0]];
		ed_rd <= ed_mem[e_q[EDGE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ns_we) ns_mem[ns_wa] <= ns_wd;
		ns_rd <= ns_mem[ns_ra];
	end

	always_ff @(posedge clk) begin
		if (fc_we) fc_mem[fc_wa] <= fc_wd;
		fc_rd <= fc_mem[ns_ra];
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		adj_rd <= adj_mem[cmd_q.idx[ADJ_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pn_mem[pt_wa] <= i_q[NODE_W-1:0];
			pp_mem[pt_wa] <= pp_wd;
		end
		pn_rd <= pn_mem[cmd_q.idx[EDGE_W-1:0]];
		pp_rd <= pp_mem[cmd_q.idx[EDGE_W-1:0]];
	end

`ifndef NO_ASSERTIONS
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= MAX_EDGES_C) else $error("edge count beyond store depth");
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_CLEAR |-> !out_valid_q) else $error("result during clearing pass");
	a_built_by_build: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(state_q == BS_BDONE)) else $error("built set outside build");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= VAL_W'(ADJ_DEPTH)) else $error("adjacency layout overflow");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/csr_graph_builder_with_parts.sv -----
// Top level of the CSR graph builder: register port, front, queue and back.
// An edge add or a read passes the front register, the queue and the back stage's read
// and done states before its result is registered; the back stage finishes one such item
// before it takes the next, set by the read-then-write pass over its block memories.
// A build walks the nodes in use, writing their part entries, and then the stored edges,
// one memory access at a time.
// After reset the degree stores are zeroed by a pass over every entry, during which
// in_stall stays high; register writes are taken throughout.
`default_nettype none
module csr_graph_builder_with_parts import csrgb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        func,
	input  wire logic [ID_W-1:0]   source_node,
	input  wire logic [ID_W-1:0]   dest_node,
	input  wire logic [IDX_W-1:0]  index,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [VAL_W-1:0]       value_a,
	output logic [VAL_W-1:0]       value_b
);

	// Configuration registers; the node count is clamped to the store size
	// before the front and back stages see it.
	logic [ID_W-1:0] node_count_q;
	logic            one_based_q;
	logic            cfg_wr;
	cfg_t            cfg;
	logic            hold, q_push, q_pop, q_empty, q_full;
	cmd_t            q_in, q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= MAX_NODES_C;
			one_based_q  <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NODE_COUNT: node_count_q <= pwdata[ID_W-1:0];
				REG_ONE_BASED:  one_based_q  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			REG_ONE_BASED:  prdata = 32'(one_based_q);
		endcase
	end

	// A write of the node count invalidates any finished layout.
	assign cfg.nodes     = (node_count_q > MAX_NODES_C) ? MAX_NODES_C : node_count_q;
	assign cfg.one_based = one_based_q;
	assign cfg.nodes_wr  = cfg_wr && (paddr[2] == REG_NODE_COUNT);

	// The front stage maps ids and range-checks against the node count; each
	// transfer becomes one queued command.
	csrgb_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .source_node, .dest_node,
		.index, .cfg, .hold, .q_full, .q_push, .q_cmd(q_in)
	);

	// The queue lets the front keep taking transfers while the back is busy.
	csrgb_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_cmd(q_in), .pop(q_pop),
		.head(q_head), .empty(q_empty), .full(q_full)
	);

	// The back stage owns every store and the result register.
	csrgb_back u_back (
		.clk, .arst_n, .cfg, .q_empty, .q_head, .q_pop, .clearing(hold),
		.out_valid, .out_stall, .status, .value_a, .value_b
	);

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the CSR graph builder: directed table, random edges, builds and reads.
`default_nettype none
module tb;
	import csrgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Register byte addresses: every register is 32 bits or narrower, so 4*i.
	localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
	localparam logic [2:0] ADDR_ONE_BASED  = 3'd4;
	localparam logic [2:0] FUNC_BAD6       = 3'd6;
	localparam logic [2:0] FUNC_BAD7       = 3'd7;
	localparam int         DIRECTED_ROWS   = 20;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        func;
	logic [ID_W-1:0]   source_node, dest_node;
	logic [IDX_W-1:0]  index;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [VAL_W-1:0]  value_a, value_b;

	csr_graph_builder_with_parts dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.source_node(source_node), .dest_node(dest_node), .index(index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_a(value_a), .value_b(value_b)
	);

	// One expected response of the block.
	typedef struct packed {
		logic [1:0]       st;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} answer_t;

	// Directed stimulus row; has_answer marks rows whose response is typed in.
	typedef struct {
		logic [2:0]       fn;
		logic [ID_W-1:0]  src;
		logic [ID_W-1:0]  dst;
		logic [IDX_W-1:0] idx;
		bit               has_answer;
		answer_t          answer;
	} row_t;

	// The predictor's private copy of the graph state and of the registers.
	logic [ID_W-1:0]   cfg_nodes;
	bit                cfg_one_based;
	int unsigned       src_list[MAX_EDGES];
	int unsigned       dst_list[MAX_EDGES];
	int unsigned       edge_total;
	int unsigned       outdeg[MAX_NODES];
	int unsigned       indeg[MAX_NODES];
	int unsigned       start_ptr[MAX_NODES];
	int unsigned       adj_store[ADJ_DEPTH];
	int unsigned       part_node_of[MAX_EDGES];
	int unsigned       part_num_of[MAX_EDGES];
	int unsigned       parts_listed;
	int unsigned       adj_used;
	bit                layout_valid;

	answer_t           pending_answers[$];
	int unsigned       errors;
	int unsigned       results_seen;
	bit                hold_receiver;
	bit                no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The run is far shorter than this; it only catches a hung block.
	initial begin
		#80ms;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned active_nodes();
		return (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
	endfunction

	// Translates an incoming id into a node index; returns 0 if it is not a valid node.
	function automatic bit node_of(input logic [ID_W-1:0] raw, output int unsigned node);
		int unsigned id;
		id = raw;
		node = 0;
		if (cfg_one_based) begin
			if (id == 0) return 0;
			id = id - 1;
		end
		if (id >= active_nodes()) return 0;
		node = id;
		return 1;
	endfunction

	// Lays out the compressed adjacency store and the part table, as a build does.
	function automatic void lay_out_graph(output int unsigned idle_nodes);
		int unsigned n, pos, slot, s, np;
		int unsigned fill[MAX_NODES];
		n = active_nodes();
		pos = 0;
		idle_nodes = 0;
		parts_listed = 0;
		for (int i = 0; i < n; i++) begin
			start_ptr[i] = pos;
			adj_store[pos] = outdeg[i];
			fill[i] = 0;
			if (outdeg[i] == 0) idle_nodes++;
			pos += outdeg[i] + 1;
		end
		for (int e = 0; e < edge_total; e++) begin
			s = src_list[e];
			if (s < n) begin
				slot = start_ptr[s] + 1 + fill[s];
				if (slot < ADJ_DEPTH) adj_store[slot] = dst_list[e];
				fill[s]++;
			end
		end
		for (int i = 0; i < n; i++) begin
			np = (outdeg[i] + PART_SPAN - 1) / PART_SPAN;
			for (int p = 0; p < np && parts_listed < MAX_EDGES; p++) begin
				part_node_of[parts_listed] = i;
				part_num_of[parts_listed] = p;
				parts_listed++;
			end
		end
		adj_used = pos;
		layout_valid = 1;
	endfunction

	// Works out the response to one item and advances the predicted state.
	function automatic answer_t graph_response(input logic [2:0] fn, input logic [ID_W-1:0] src,
			input logic [ID_W-1:0] dst, input logic [IDX_W-1:0] idx);
		answer_t r;
		int unsigned s, d, zeros;
		int unsigned ix;
		ix = idx;
		r = '0;
		case (fn)
			FUNC_ADD: begin
				if (!node_of(src, s) || !node_of(dst, d) || edge_total >= MAX_EDGES) begin
					r.st = STAT_ERR;
				end else begin
					src_list[edge_total] = s;
					dst_list[edge_total] = d;
					edge_total++;
					outdeg[s]++;
					indeg[d]++;
					layout_valid = 0;
				end
				r.a = VAL_W'(edge_total);
			end
			FUNC_BUILD: begin
				lay_out_graph(zeros);
				r.a = VAL_W'(parts_listed);
				r.b = VAL_W'(zeros);
			end
			FUNC_RD_START: begin
				if (!layout_valid) r.st = STAT_UNBUILT;
				else if (ix >= active_nodes()) r.st = STAT_ERR;
				else r.a = VAL_W'(start_ptr[ix]);
			end
			FUNC_RD_WORD: begin
				if (!layout_valid) r.st = STAT_UNBUILT;
				else if (ix >= adj_used || ix >= ADJ_DEPTH) r.st = STAT_ERR;
				else r.a = VAL_W'(adj_store[ix]);
			end
			FUNC_RD_PART: begin
				if (!layout_valid) r.st = STAT_UNBUILT;
				else if (ix >= parts_listed) r.st = STAT_ERR;
				else begin
					r.a = VAL_W'(part_node_of[ix]);
					r.b = VAL_W'(part_num_of[ix]);
				end
			end
			FUNC_RD_DEG: begin
				if (ix >= active_nodes()) r.st = STAT_ERR;
				else begin
					r.a = VAL_W'(outdeg[ix]);
					r.b = VAL_W'(indeg[ix]);
				end
			end
			default: r.st = STAT_ERR;
		endcase
		return r;
	endfunction

	// APB write: a setup phase, then an access phase; pready is always high.
	task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_NODE_COUNT) begin
			cfg_nodes = data[ID_W-1:0];
			layout_valid = 0;
		end else begin
			cfg_one_based = data[0];
		end
	endtask

	// Offers one item until the block takes it. The predictor runs at the transfer so
	// its state stays in order with the block. An expected answer typed into the table
	// is checked against the predictor too, which keeps the predictor honest.
	// Valid stays high after the transfer; the next item replaces or lowers it, or the caller lowers it.
	task automatic send_item(input logic [2:0] fn, input logic [ID_W-1:0] src,
			input logic [ID_W-1:0] dst, input logic [IDX_W-1:0] idx,
			input bit has_answer, input answer_t typed);
		answer_t r;
		// Random gaps ahead of the item, except in the stretch with no idling.
		while (!no_idle && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		source_node <= src;
		dest_node <= dst;
		index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = graph_response(fn, src, dst, idx);
		if (has_answer && r != typed) begin
			$display("%0t directed row: expected %h, predictor gives %h", $time, typed, r);
			errors++;
		end
		pending_answers.push_back(has_answer ? typed : r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// A random id: mostly valid under the current setting, sometimes any 11-bit value.
	function automatic logic [ID_W-1:0] pick_id(input int unsigned span);
		if ($urandom_range(99) < 8) return ID_W'($urandom);
		if (cfg_one_based) return ID_W'($urandom_range(span, 1));
		return ID_W'($urandom_range(span - 1, 0));
	endfunction

	// One random item. Edge adds dominate; reads pick indexes mostly inside the built range.
	task automatic send_random_item(input int unsigned span);
		int unsigned pick;
		logic [2:0] fn;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(99);
		idx = IDX_W'($urandom);
		if (pick < 50) fn = FUNC_ADD;
		else if (pick < 53) fn = FUNC_BUILD;
		else if (pick < 62) fn = FUNC_RD_START;
		else if (pick < 76) fn = FUNC_RD_WORD;
		else if (pick < 85) fn = FUNC_RD_PART;
		else if (pick < 97) fn = FUNC_RD_DEG;
		else fn = $urandom_range(1) ? FUNC_BAD6 : FUNC_BAD7;
		if ($urandom_range(9) < 8) begin
			case (fn)
				FUNC_RD_WORD: idx = IDX_W'($urandom_range(adj_used + 2, 0));
				FUNC_RD_PART: idx = IDX_W'($urandom_range(parts_listed + 1, 0));
				default:      idx = IDX_W'($urandom_range(active_nodes(), 0));
			endcase
		end
		send_item(fn, pick_id(span), pick_id(span), idx, 0, '0);
	endtask

	// Receiver: random stalls, one long hold-off, and the comparison of every result.
	initial begin
		answer_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) out_stall <= 1'b1;
			else out_stall <= (!no_idle && $urandom_range(99) < 37);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_answers.size() == 0) begin
					$display("%0t unexpected transfer: status %0d a %0d b %0d",
						$time, status, value_a, value_b);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (status !== want.st)
						$display("%0t status: expected %0d, actual %0d", $time, want.st, status);
					if (value_a !== want.a)
						$display("%0t value_a: expected %0d, actual %0d", $time, want.a, value_a);
					if (value_b !== want.b)
						$display("%0t value_b: expected %0d, actual %0d", $time, want.b, value_b);
					if (status !== want.st || value_a !== want.a || value_b !== want.b)
						errors++;
				end
			end
		end
	end

	row_t table_rows[DIRECTED_ROWS];

	initial begin
		int unsigned span;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_ADD;
		source_node = '0;
		dest_node = '0;
		index = '0;
		hold_receiver = 0;
		no_idle = 0;
		errors = 0;
		results_seen = 0;
		cfg_nodes = MAX_NODES_C;
		cfg_one_based = 1;
		edge_total = 0;
		parts_listed = 0;
		adj_used = 0;
		layout_valid = 0;
		foreach (outdeg[i]) begin
			outdeg[i] = 0;
			indeg[i] = 0;
		end

		// Directed table at reset settings (1024 nodes, one-based ids). Rows with a
		// typed answer are the obvious ones; the rest lean on the predictor.
		table_rows = '{
			'{FUNC_RD_START, 11'd0, 11'd0, 13'd0, 1, '{STAT_UNBUILT, 13'd0, 13'd0}},
			'{FUNC_RD_WORD,  11'd0, 11'd0, 13'd0, 1, '{STAT_UNBUILT, 13'd0, 13'd0}},
			'{FUNC_RD_PART,  11'd0, 11'd0, 13'd0, 1, '{STAT_UNBUILT, 13'd0, 13'd0}},
			'{FUNC_RD_DEG,   11'd0, 11'd0, 13'd0, 1, '{STAT_OK, 13'd0, 13'd0}},
			'{FUNC_ADD,      11'd0, 11'd1, 13'd0, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_ADD,      11'd1025, 11'd1, 13'd0, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_ADD,      11'd2047, 11'd1, 13'd0, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_ADD,      11'd1, 11'd1024, 13'd0, 1, '{STAT_OK, 13'd1, 13'd0}},
			'{FUNC_ADD,      11'd1024, 11'd1, 13'd0, 1, '{STAT_OK, 13'd2, 13'd0}},
			'{FUNC_ADD,      11'd1, 11'd2, 13'd0, 1, '{STAT_OK, 13'd3, 13'd0}},
			'{FUNC_BUILD,    11'd0, 11'd0, 13'd0, 0, '0},
			'{FUNC_RD_START, 11'd0, 11'd0, 13'd1023, 0, '0},
			'{FUNC_RD_START, 11'd0, 11'd0, 13'd1024, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_RD_WORD,  11'd0, 11'd0, 13'd2, 0, '0},
			'{FUNC_RD_WORD,  11'd0, 11'd0, 13'd8191, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_RD_PART,  11'd0, 11'd0, 13'd1, 0, '0},
			'{FUNC_RD_PART,  11'd0, 11'd0, 13'd2, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_RD_DEG,   11'd0, 11'd0, 13'd1023, 0, '0},
			'{FUNC_BAD6,     11'd0, 11'd0, 13'd0, 1, '{STAT_ERR, 13'd0, 13'd0}},
			'{FUNC_BAD7,     11'h7ff, 11'h7ff, 13'h1fff, 1, '{STAT_ERR, 13'd0, 13'd0}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Both values of the one-based register and the top node count first; the degree clearing pass runs meanwhile.
		write_register(ADDR_ONE_BASED, 32'd0);
		write_register(ADDR_ONE_BASED, 32'd1);
		write_register(ADDR_NODE_COUNT, 32'(MAX_NODES));

		foreach (table_rows[i])
			send_item(table_rows[i].fn, table_rows[i].src, table_rows[i].dst,
				table_rows[i].idx, table_rows[i].has_answer, table_rows[i].answer);
		drain_results();

		// Random phases under several settings. Small node counts keep builds short and
		// give dense adjacency lists; zero nodes and the top count are included.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: span = 1;
				1: span = 8;
				2: span = 2047;
				3: span = 30;
				4: span = 0;
				5: span = 1024;
				default: span = $urandom_range(60, 2);
			endcase
			write_register(ADDR_NODE_COUNT, 32'(span));
			write_register(ADDR_ONE_BASED, 32'(phase % 2));
			span = (span == 0) ? 1 : ((span > MAX_NODES) ? MAX_NODES : span);
			no_idle = (phase == 3);
			if (phase == 1) begin
				// Long receiver hold-off, counted here, while items keep coming.
				fork
					begin
						hold_receiver = 1;
						repeat (300) @(posedge clk);
						hold_receiver = 0;
					end
				join_none
			end
			for (int k = 0; k < 115; k++) begin
				send_random_item(span);
				if (k % 40 == 39) begin
					send_item(FUNC_BUILD, '0, '0, '0, 0, '0);
					// At k == 79 the sender waits here until every answer has come back.
					if (k == 79) begin
						in_valid <= 1'b0;
						while (pending_answers.size() != 0) @(posedge clk);
					end
				end
			end
			send_item(FUNC_BUILD, '0, '0, '0, 0, '0);
			drain_results();
			no_idle = 0;
		end

		drain_results();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- csr_graph_builder_with_parts.f -----
hw/rtl/csrgb_pkg.sv
hw/rtl/csrgb_front.sv
hw/rtl/csrgb_queue.sv
hw/rtl/csrgb_back.sv
hw/rtl/csr_graph_builder_with_parts.sv
tb/tb.sv
